>>> rtl/bra_pkg.sv
// Shared types and constants for the bitmap run allocator.
// No dependencies; used by bra_run_find and bitmap_run_allocator.
`default_nettype none

package bra_pkg;

    localparam int BYTE_BITS  = 8;
    localparam int WORD_BITS  = 32;
    localparam int WORD_BYTES = WORD_BITS / BYTE_BITS;
    localparam int POS_W      = $clog2(WORD_BITS);      // bit position inside a word
    localparam int IDX_W      = 10;                     // bit_index width
    localparam int RUN_LEN_W  = 11;                     // run_length width
    localparam int IDX_BYTES  = (2 ** IDX_W) / BYTE_BITS; // bytes reachable by bit_index
    localparam int CFG_W      = 8;                      // bytes_in_use width
    localparam int SWORD_W    = 7;                      // scan word index, up to 255 bytes
    localparam int SBYTE_W    = SWORD_W + 2;            // scan byte index
    localparam int RUN_W      = 12;                     // run counter, holds up to 2040 bits

    localparam logic [BYTE_BITS-1:0] FULL_BYTE     = 8'hff;
    localparam logic [CFG_W-1:0]     BYTES_AT_RESET = 8'd128;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_TEST  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_SCAN  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]           command;
        logic [IDX_W-1:0]     bit_index;
        logic                 bit_value;
        logic [RUN_LEN_W-1:0] run_length;
    } in_item_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] start_index;
        logic             bit_state;
    } out_item_t;

    // result of looking at one 32-bit word of the map
    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] end_pos;
        logic [RUN_W-1:0] carry_next;
    } find_t;

endpackage

`default_nettype wire

>>> rtl/bra_run_find.sv
// Run finder for one 32-bit map word: first position where the free run reaches the target.
// Depends on bra_pkg.
`default_nettype none

module bra_run_find (
    input  wire logic [bra_pkg::WORD_BITS-1:0] used_word,
    input  wire logic [bra_pkg::RUN_W-1:0]     carry_in,
    input  wire logic [bra_pkg::RUN_LEN_W-1:0] want,
    output bra_pkg::find_t                      result
);

    logic [bra_pkg::RUN_W-1:0] run_len [bra_pkg::WORD_BITS];
    logic [bra_pkg::WORD_BITS-1:0] reach;

    // run ending at each bit: distance to the last used bit at or below it,
    // or the carried run plus the bits so far when the word is free up to there
    always_comb begin
        logic                     any_used;
        logic [bra_pkg::POS_W-1:0] last_used;
        for (int j = 0; j < bra_pkg::WORD_BITS; j++) begin
            any_used  = 1'b0;
            last_used = '0;
            for (int k = 0; k <= j; k++) begin
                if (used_word[k]) begin
                    any_used  = 1'b1;
                    last_used = bra_pkg::POS_W'(k);
                end
            end
            if (any_used) begin
                run_len[j] = bra_pkg::RUN_W'(j) - bra_pkg::RUN_W'(last_used);
            end else begin
                run_len[j] = carry_in + bra_pkg::RUN_W'(j + 1);
            end
            reach[j] = (run_len[j] >= bra_pkg::RUN_W'(want));
        end
    end

    always_comb begin
        result.hit        = |reach;
        result.end_pos    = '0;
        result.carry_next = run_len[bra_pkg::WORD_BITS-1];
        for (int j = bra_pkg::WORD_BITS - 1; j >= 0; j--) begin
            if (reach[j]) begin
                result.end_pos = bra_pkg::POS_W'(j);
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/bitmap_run_allocator.sv
// Bitmap run allocator top level: map storage, command sequencer, result register.
// Depends on bra_pkg and bra_run_find.
//
// Usage:
//  - s_valid/s_ready/s_data take one command item: clear all, test bit, write bit,
//    or first-fit scan for run_length free bits. Each item yields one result item
//    on m_valid/m_ready/m_data (found, start_index, bit_state).
//  - cfg_wr_en/cfg_wr_data write bytes_in_use (bytes managed, clamped to MAP_BYTES);
//    write it only while the block is idle.
//  - Clear goes straight to the result; test and write read the map word on accept,
//    then take the access step (map write or bit test) before the result. Scan reads
//    the 32-bit map words in turn and checks each in the shared run finder on the map
//    read port, up to the word that completes the run or the last managed word.
//  - The block takes one item at a time; s_ready is high only when idle, so a new
//    item is taken only after the last one's result has been loaded into the output
//    register. A finished result waits there, so the next item is accepted while
//    the receiver stalls; that item's result is held until the register empties.
//  - Reset: bytes_in_use returns to 128 and the whole map reads as free at once
//    (per-byte valid flags), so no clearing pass is needed.
`default_nettype none

module bitmap_run_allocator #(
    parameter int MAP_BYTES = 128
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire bra_pkg::in_item_t         s_data,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output bra_pkg::out_item_t             m_data,
    input  wire logic                      cfg_wr_en,
    input  wire logic [bra_pkg::CFG_W-1:0] cfg_wr_data
);

    // only the first 1024 bits can ever be written; bytes past that read as free
    localparam int PHYS_BYTES = (MAP_BYTES < bra_pkg::IDX_BYTES) ? MAP_BYTES
                                                                : bra_pkg::IDX_BYTES;
    localparam int PHYS_WORDS = (PHYS_BYTES + bra_pkg::WORD_BYTES - 1) / bra_pkg::WORD_BYTES;
    localparam int AW         = (PHYS_WORDS > 1) ? $clog2(PHYS_WORDS) : 1;
    localparam int VB_W       = (PHYS_BYTES > 1) ? $clog2(PHYS_BYTES) : 1;
    localparam int WB         = bra_pkg::WORD_BITS;
    localparam int BB         = bra_pkg::BYTE_BITS;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_ACCESS = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [bra_pkg::CFG_W-1:0]     bytes_in_use_reg, bytes_in_use_next;
    logic [1:0]                    cmd_reg, cmd_next;
    logic [bra_pkg::IDX_W-1:0]     acc_idx_reg, acc_idx_next;
    logic                          acc_val_reg, acc_val_next;
    logic [bra_pkg::RUN_LEN_W-1:0] want_reg, want_next;
    logic [bra_pkg::SWORD_W-1:0]   iw_reg, iw_next;         // next word to read
    logic [bra_pkg::SWORD_W-1:0]   proc_w_reg, proc_w_next; // word in rd_data_reg
    logic [bra_pkg::RUN_W-1:0]     carry_reg, carry_next;   // free run entering the word
    logic                          res_found_reg, res_found_next;
    logic                          res_bit_reg, res_bit_next;
    logic                          scan_hit_reg, scan_hit_next;
    logic [bra_pkg::RUN_W-1:0]     end_reg, end_next;       // last bit of the found run
    logic                          m_valid_reg, m_valid_next;
    bra_pkg::out_item_t            m_data_reg, m_data_next;

    // per-byte valid flags: an invalid byte reads as all free
    logic [PHYS_BYTES-1:0] byte_vld_reg;

    // map storage
    logic [WB-1:0] mem [PHYS_WORDS];
    logic [WB-1:0] rd_data_reg;
    logic          mem_re, mem_we;
    logic [AW-1:0] mem_raddr, mem_waddr;
    logic [WB-1:0] mem_wdata;

    logic                        accept;
    logic                        clr_all;
    logic [bra_pkg::CFG_W-1:0]   managed;
    logic [bra_pkg::SWORD_W-1:0] nwords;
    logic                        acc_in_range;
    logic [WB-1:0]               acc_word;
    logic [WB-1:0]               scan_word;
    logic [WB-1:0]               bit_mask;
    bra_pkg::find_t              find;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // managed size; bytes_in_use is at most 255 so the clamp result fits 8 bits
    assign managed = (32'(bytes_in_use_reg) > MAP_BYTES) ? bra_pkg::CFG_W'(MAP_BYTES)
                                                         : bytes_in_use_reg;
    assign nwords  = bra_pkg::SWORD_W'((9'(managed) + 9'd3) >> 2);

    assign acc_in_range = (32'(acc_idx_reg[bra_pkg::IDX_W-1:3]) < PHYS_BYTES);

    // word being tested or written, invalid bytes shown as free
    always_comb begin
        logic [6:0] g;
        for (int b = 0; b < bra_pkg::WORD_BYTES; b++) begin
            g = {acc_idx_reg[bra_pkg::IDX_W-1:bra_pkg::POS_W], 2'(b)};
            if ((32'(g) < PHYS_BYTES) && byte_vld_reg[VB_W'(g)]) begin
                acc_word[b*BB +: BB] = rd_data_reg[b*BB +: BB];
            end else begin
                acc_word[b*BB +: BB] = '0;
            end
        end
    end

    // word under scan: bytes past the managed size count as used so no run crosses them
    always_comb begin
        logic [bra_pkg::SBYTE_W-1:0] g;
        for (int b = 0; b < bra_pkg::WORD_BYTES; b++) begin
            g = {proc_w_reg, 2'(b)};
            if (g >= bra_pkg::SBYTE_W'(managed)) begin
                scan_word[b*BB +: BB] = bra_pkg::FULL_BYTE;
            end else if ((32'(g) < PHYS_BYTES) && byte_vld_reg[VB_W'(g)]) begin
                scan_word[b*BB +: BB] = rd_data_reg[b*BB +: BB];
            end else begin
                scan_word[b*BB +: BB] = '0;
            end
        end
    end

    bra_run_find u_find (
        .used_word (scan_word),
        .carry_in  (carry_reg),
        .want      (want_reg),
        .result    (find)
    );

    assign bit_mask  = WB'(1) << acc_idx_reg[bra_pkg::POS_W-1:0];
    assign mem_wdata = acc_val_reg ? (acc_word | bit_mask) : (acc_word & ~bit_mask);
    assign mem_waddr = AW'(acc_idx_reg[bra_pkg::IDX_W-1:bra_pkg::POS_W]);
    assign mem_we    = (state_reg == ST_ACCESS) && (cmd_reg == bra_pkg::CMD_WRITE)
                       && acc_in_range;

    // read port: command word on accept, then one word per cycle while scanning
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = '0;
        if (accept) begin
            if (s_data.command == bra_pkg::CMD_SCAN) begin
                mem_re = 1'b1;
            end else begin
                mem_re    = 32'(s_data.bit_index[bra_pkg::IDX_W-1:3]) < PHYS_BYTES;
                mem_raddr = AW'(s_data.bit_index[bra_pkg::IDX_W-1:bra_pkg::POS_W]);
            end
        end else if (state_reg == ST_SCAN) begin
            mem_re    = 32'(iw_reg) < PHYS_WORDS;
            mem_raddr = AW'(iw_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // sequencer
    always_comb begin
        state_next        = state_reg;
        bytes_in_use_next = cfg_wr_en ? cfg_wr_data : bytes_in_use_reg;
        cmd_next          = cmd_reg;
        acc_idx_next      = acc_idx_reg;
        acc_val_next      = acc_val_reg;
        want_next         = want_reg;
        iw_next           = iw_reg;
        proc_w_next       = proc_w_reg;
        carry_next        = carry_reg;
        res_found_next    = res_found_reg;
        res_bit_next      = res_bit_reg;
        scan_hit_next     = scan_hit_reg;
        end_next          = end_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_data_next       = m_data_reg;
        clr_all           = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd_next       = s_data.command;
                    acc_idx_next   = s_data.bit_index;
                    acc_val_next   = s_data.bit_value;
                    want_next      = s_data.run_length;
                    res_found_next = 1'b1;
                    res_bit_next   = 1'b0;
                    scan_hit_next  = 1'b0;
                    unique case (bra_pkg::cmd_t'(s_data.command))
                        bra_pkg::CMD_CLEAR: begin
                            clr_all    = 1'b1;
                            state_next = ST_FINISH;
                        end
                        bra_pkg::CMD_TEST, bra_pkg::CMD_WRITE: begin
                            state_next = ST_ACCESS;
                        end
                        bra_pkg::CMD_SCAN: begin
                            if ((s_data.run_length == '0) || (managed == '0)) begin
                                res_found_next = 1'b0;
                                state_next     = ST_FINISH;
                            end else begin
                                iw_next     = bra_pkg::SWORD_W'(1);
                                proc_w_next = '0;
                                carry_next  = '0;
                                state_next  = ST_SCAN;
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ACCESS: begin
                if (cmd_reg == bra_pkg::CMD_TEST) begin
                    res_bit_next = acc_in_range
                                   && acc_word[acc_idx_reg[bra_pkg::POS_W-1:0]];
                end
                state_next = ST_FINISH;
            end
            ST_SCAN: begin
                if (find.hit) begin
                    scan_hit_next  = 1'b1;
                    end_next       = {proc_w_reg, find.end_pos};
                    res_found_next = 1'b1;
                    state_next     = ST_FINISH;
                end else if (proc_w_reg == nwords - bra_pkg::SWORD_W'(1)) begin
                    res_found_next = 1'b0;
                    state_next     = ST_FINISH;
                end else begin
                    carry_next  = find.carry_next;
                    proc_w_next = iw_reg;
                    iw_next     = iw_reg + bra_pkg::SWORD_W'(1);
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    m_data_next.found     = res_found_reg;
                    m_data_next.bit_state = res_bit_reg;
                    m_data_next.start_index = scan_hit_reg
                        ? bra_pkg::IDX_W'(end_reg + bra_pkg::RUN_W'(1)
                                          - bra_pkg::RUN_W'(want_reg))
                        : '0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            bytes_in_use_reg <= bra_pkg::BYTES_AT_RESET;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            bytes_in_use_reg <= bytes_in_use_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        acc_idx_reg   <= acc_idx_next;
        acc_val_reg   <= acc_val_next;
        want_reg      <= want_next;
        iw_reg        <= iw_next;
        proc_w_reg    <= proc_w_next;
        carry_reg     <= carry_next;
        res_found_reg <= res_found_next;
        res_bit_reg   <= res_bit_next;
        scan_hit_reg  <= scan_hit_next;
        end_reg       <= end_next;
        m_data_reg    <= m_data_next;
    end

    // valid flags: reset drops them all, clear-all drops those of the managed bytes, a write marks its whole word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_vld_reg <= '0;
        end else begin
            for (int i = 0; i < PHYS_BYTES; i++) begin
                if (clr_all && (i < 32'(managed))) begin
                    byte_vld_reg[i] <= 1'b0;
                end else if (mem_we
                             && ((i / bra_pkg::WORD_BYTES)
                                 == 32'(acc_idx_reg[bra_pkg::IDX_W-1:bra_pkg::POS_W]))) begin
                    byte_vld_reg[i] <= 1'b1;
                end
            end
        end
    end

`ifndef SYNTHESIS
    // one item at a time: an accepted item keeps the input closed next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("input open right after an accepted item");

    // the scan never runs past the last managed word
    a_scan_in_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (proc_w_reg < nwords))
        else $error("scan word beyond managed size");

    // the carried free run cannot exceed the managed bit count
    a_carry_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (carry_reg <= bra_pkg::RUN_W'({managed, 3'b000})))
        else $error("free run longer than the map");

    // a finished result waits while the output register is still full
    a_finish_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && m_valid_reg && !m_ready) |=> (state_reg == ST_FINISH))
        else $error("result dropped while output stalled");
`endif

endmodule

`default_nettype wire
